@@ hdl/nearest_neighbor_image_scaler_core_assert.svh @@
// Assertion macros used by the checker of the nearest-neighbor scaler core.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NNS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nns assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define NNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nns assertion failed");

`endif

@@ hdl/nns_pkg.sv @@
// Types and constants of the nearest-neighbor scaler core.
package nns_pkg;

    // Transfer field widths
    localparam int unsigned COORD_W  = 13;
    localparam int unsigned DIM_W    = 10;
    localparam int unsigned SCALE_W  = 12;
    localparam int unsigned PIX_W    = 24;
    localparam int unsigned OSIZE_W  = 17;

    // Divider: numerator up to 512*8191+4095, divisor up to 2*4095
    localparam int unsigned DIV_N_W  = 23;
    localparam int unsigned DIV_D_W  = 13;
    localparam int unsigned CNT_W    = 5;
    localparam logic [CNT_W-1:0] DIV_LAST = 5'd22;

    // Configuration port
    localparam int unsigned PADDR_W  = 5;
    localparam int unsigned PDATA_W  = 32;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] REG_HSCALE     = 3'd2;
    localparam logic [2:0] REG_VSCALE     = 3'd3;
    localparam logic [2:0] REG_TRI_MODE   = 3'd4;

    // Item codes
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    // Lanes of the divider
    localparam int unsigned LANE_ROW = 0;
    localparam int unsigned LANE_COL = 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SIZE,
        ST_DIV,
        ST_ADDR,
        ST_READ,
        ST_DONE
    } t_state;

endpackage

@@ hdl/nearest_neighbor_image_scaler_core.sv @@
// Nearest-neighbor image scaler core: frame store, index divider, result register.
// Load: the pixel is written in the cycle after the transfer, while the input is closed.
// Fetch: SIZE, DIV, ADDR, READ, DONE follow the transfer; no new item until DONE loads
// the result. The 23-step restoring divider gives one quotient bit per cycle per axis.
// Reset (synchronous, active low) returns config to 512x512, unity scale, three-channel,
// and empties the control path; frame store contents stay undefined until written.
module nearest_neighbor_image_scaler_core
    import nns_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_func,
    input  logic [COORD_W-1:0]    i_pixel_row,
    input  logic [COORD_W-1:0]    i_pixel_col,
    input  logic [7:0]            i_comp0_in,
    input  logic [7:0]            i_comp1_in,
    input  logic [7:0]            i_comp2_in,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_comp0_out,
    output logic [7:0]            o_comp1_out,
    output logic [7:0]            o_comp2_out,
    output logic                  o_inside_source,
    output logic                  o_beyond_output,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [COORD_W-1:0] MAX_W_C = COORD_W'(MAX_WIDTH);
    localparam logic [COORD_W-1:0] MAX_H_C = COORD_W'(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   r_src_w;
    logic [DIM_W-1:0]   r_src_h;
    logic [SCALE_W-1:0] r_hscale;
    logic [SCALE_W-1:0] r_vscale;
    logic               r_tri;
    logic               w_cfg_we;

    assign pready   = 1'b1;
    assign w_cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= 10'd512;
            r_src_h  <= 10'd512;
            r_hscale <= 12'd256;
            r_vscale <= 12'd256;
            r_tri    <= 1'b1;
        end else if (w_cfg_we) begin
            unique case (paddr[4:2])
                REG_SRC_WIDTH:  r_src_w  <= pwdata[DIM_W-1:0];
                REG_SRC_HEIGHT: r_src_h  <= pwdata[DIM_W-1:0];
                REG_HSCALE:     r_hscale <= pwdata[SCALE_W-1:0];
                REG_VSCALE:     r_vscale <= pwdata[SCALE_W-1:0];
                REG_TRI_MODE:   r_tri    <= pwdata[0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SRC_WIDTH:  prdata = PDATA_W'(r_src_w);
            REG_SRC_HEIGHT: prdata = PDATA_W'(r_src_h);
            REG_HSCALE:     prdata = PDATA_W'(r_hscale);
            REG_VSCALE:     prdata = PDATA_W'(r_vscale);
            REG_TRI_MODE:   prdata = PDATA_W'(r_tri);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state, n_state;
    logic   w_in_xfer;
    logic   w_out_load;
    logic   w_mem_we;
    logic   w_mem_re;
    logic   w_div_init;
    logic   w_div_step;
    logic   w_addr_en;
    logic   r_out_valid;
    logic [CNT_W-1:0] r_cnt;

    assign w_in_xfer = i_in_valid & o_in_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_xfer) begin
                n_state = (i_func == FUNC_FETCH) ? ST_SIZE : ST_WRITE;
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_SIZE:  n_state = ST_DIV;
            ST_DIV:   if (r_cnt == DIV_LAST) begin
                n_state = ST_ADDR;
            end
            ST_ADDR:  n_state = ST_READ;
            ST_READ:  n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || i_out_ready) begin
                n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_re   = 1'b0;
        w_div_init = 1'b0;
        w_div_step = 1'b0;
        w_addr_en  = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_WRITE: w_mem_we   = 1'b1;
            ST_SIZE:  w_div_init = 1'b1;
            ST_DIV:   w_div_step = 1'b1;
            ST_ADDR:  w_addr_en  = 1'b1;
            ST_READ:  w_mem_re   = 1'b1;
            ST_DONE:  w_out_load = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Item capture
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] r_row;
    logic [COORD_W-1:0] r_col;
    logic [7:0]         r_c0, r_c1, r_c2;

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_row <= i_pixel_row;
            r_col <= i_pixel_col;
            r_c0  <= i_comp0_in;
            r_c1  <= i_comp1_in;
            r_c2  <= i_comp2_in;
        end
    end

    // ------------------------------------------------------------------
    // Output size: round(clamped source * scale) in Q4.8
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] w_sw, w_sh;
    logic [COORD_W-1:0] r_sw, r_sh;
    logic [OSIZE_W-1:0] r_ow, r_oh;

    // saturate the register dimensions at the store size
    assign w_sw = (COORD_W'(r_src_w) > MAX_W_C) ? MAX_W_C : COORD_W'(r_src_w);
    assign w_sh = (COORD_W'(r_src_h) > MAX_H_C) ? MAX_H_C : COORD_W'(r_src_h);

    always_ff @(posedge i_clk) begin
        if (w_div_init) begin
            r_sw <= w_sw;
            r_sh <= w_sh;
            r_ow <= OSIZE_W'((25'(w_sw) * 25'(r_hscale) + 25'd128) >> 8);
            r_oh <= OSIZE_W'((25'(w_sh) * 25'(r_vscale) + 25'd128) >> 8);
        end
    end

    // ------------------------------------------------------------------
    // Index divider, one lane per axis, one quotient bit per cycle.
    // Rounding mode: (512*out + s) / (2*s); truncating mode: (256*out) / s.
    // The numerator shifts out at the top while quotient bits shift in below.
    // ------------------------------------------------------------------
    logic [DIV_N_W-1:0] r_quo [2];
    logic [DIV_D_W-1:0] r_rem [2];
    logic [DIV_D_W-1:0] r_dvs [2];
    logic [DIV_N_W-1:0] w_num_init [2];
    logic [DIV_D_W-1:0] w_dvs_init [2];
    logic [DIV_D_W-1:0] w_rem_next [2];
    logic               w_qbit [2];

    always_comb begin
        logic [COORD_W-1:0] coord;
        logic [SCALE_W-1:0] scale;
        logic [DIV_D_W:0]   trial;
        for (int l = 0; l < 2; l++) begin
            coord = (l == LANE_ROW) ? r_row : r_col;
            scale = (l == LANE_ROW) ? r_vscale : r_hscale;
            if (r_tri) begin
                w_num_init[l] = DIV_N_W'({coord, 9'd0}) + DIV_N_W'(scale);
                w_dvs_init[l] = {scale, 1'b0};
            end else begin
                w_num_init[l] = DIV_N_W'({coord, 8'd0});
                w_dvs_init[l] = DIV_D_W'(scale);
            end
            trial = {r_rem[l], r_quo[l][DIV_N_W-1]};
            w_qbit[l] = (trial >= {1'b0, r_dvs[l]});
            w_rem_next[l] = w_qbit[l] ? DIV_D_W'(trial - {1'b0, r_dvs[l]})
                                      : trial[DIV_D_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (w_div_init) begin
                r_quo[l] <= w_num_init[l];
                r_rem[l] <= '0;
                r_dvs[l] <= w_dvs_init[l];
            end else if (w_div_step) begin
                r_quo[l] <= {r_quo[l][DIV_N_W-2:0], w_qbit[l]};
                r_rem[l] <= w_rem_next[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_div_init) begin
            r_cnt <= '0;
        end else if (w_div_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Range checks and store address of the mapped source pixel
    // ------------------------------------------------------------------
    logic          w_beyond;
    logic          r_beyond;
    logic          r_inside;
    logic [AW-1:0] r_addr;

    assign w_beyond = (OSIZE_W'(r_row) >= r_oh) || (OSIZE_W'(r_col) >= r_ow);

    always_ff @(posedge i_clk) begin
        if (w_addr_en) begin
            r_beyond <= w_beyond;
            // a zero scale always lands beyond, so the quotient is never used then
            r_inside <= !w_beyond
                     && (r_quo[LANE_ROW] < DIV_N_W'(r_sh))
                     && (r_quo[LANE_COL] < DIV_N_W'(r_sw));
            r_addr   <= AW'(AW'(r_quo[LANE_ROW][RW-1:0]) * AW'(MAX_WIDTH))
                      + AW'(r_quo[LANE_COL][CW-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Frame store: one write port, one registered read port
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;
    logic [AW-1:0]    w_wr_addr;
    logic             w_wr_hit;
    logic [PIX_W-1:0] w_wr_data;

    // loads outside the store are dropped
    assign w_wr_hit  = (r_row < MAX_H_C) && (r_col < MAX_W_C);
    assign w_wr_addr = AW'(AW'(r_row[RW-1:0]) * AW'(MAX_WIDTH)) + AW'(r_col[CW-1:0]);
    assign w_wr_data = {r_tri ? r_c2 : 8'd0, r_tri ? r_c1 : 8'd0, r_c0};

    always_ff @(posedge i_clk) begin
        if (w_mem_we && w_wr_hit) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        if (w_mem_re) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // ------------------------------------------------------------------
    // Result register: parts the sequencer from the downstream side
    // ------------------------------------------------------------------
    logic [7:0] r_o_c0, r_o_c1, r_o_c2;
    logic       r_o_inside, r_o_beyond;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            // zero the bytes outside the source and the upper bytes in one-channel mode
            r_o_c0     <= r_inside ? r_rd_data[7:0] : 8'd0;
            r_o_c1     <= (r_inside && r_tri) ? r_rd_data[15:8] : 8'd0;
            r_o_c2     <= (r_inside && r_tri) ? r_rd_data[23:16] : 8'd0;
            r_o_inside <= r_inside;
            r_o_beyond <= r_beyond;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_comp0_out     = r_o_c0;
    assign o_comp1_out     = r_o_c1;
    assign o_comp2_out     = r_o_c2;
    assign o_inside_source = r_o_inside;
    assign o_beyond_output = r_o_beyond;

endmodule

@@ hdl/nns_checker.sv @@
// Port-level checker of the nearest-neighbor scaler core, with its bind.
`include "nearest_neighbor_image_scaler_core_assert.svh"

module nns_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_comp0_out,
    input logic [7:0] o_comp1_out,
    input logic [7:0] o_comp2_out,
    input logic       o_inside_source,
    input logic       o_beyond_output
);

    // a result beyond the output size carries no pixel and is never inside
    `NNS_ASSERT_NOW(a_beyond_empty, i_clk, i_rst_n, o_out_valid && o_beyond_output, !o_inside_source && o_comp0_out == 8'd0 && o_comp1_out == 8'd0 && o_comp2_out == 8'd0)

    // a pixel outside the source reads as zero
    `NNS_ASSERT_NOW(a_outside_zero, i_clk, i_rst_n, o_out_valid && !o_inside_source, o_comp0_out == 8'd0 && o_comp1_out == 8'd0 && o_comp2_out == 8'd0)

    // one item at a time: a transfer closes the input until the item is done
    `NNS_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready && !$rose(o_out_valid))

    // a stalled result holds
    `NNS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_comp0_out) && $stable(o_inside_source))

endmodule

bind nearest_neighbor_image_scaler_core nns_checker u_nns_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_comp0_out     (o_comp0_out),
    .o_comp1_out     (o_comp1_out),
    .o_comp2_out     (o_comp2_out),
    .o_inside_source (o_inside_source),
    .o_beyond_output (o_beyond_output)
);
